### sv/bpts_pkg.sv
// Shared types and constants for the bitmap priority task scheduler.
// Holds the request and result payload structs and the controller/datapath link.
// No dependencies.
package bpts_pkg;

    localparam int NUM_PRIOS_DEF   = 32;
    localparam int DELAY_WIDTH_DEF = 16;

    localparam logic [7:0] LOCK_MAX = 8'd255;

    localparam logic [2:0] ACT_START  = 3'd0;
    localparam logic [2:0] ACT_TICK   = 3'd1;
    localparam logic [2:0] ACT_DELAY  = 3'd2;
    localparam logic [2:0] ACT_LOCK   = 3'd3;
    localparam logic [2:0] ACT_UNLOCK = 3'd4;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] delay_ticks;
    } req_t;

    typedef struct packed {
        logic        switch_now;
        logic [4:0]  running_prio;
        logic        none_ready;
        logic [7:0]  lock_level;
        logic [31:0] ready_mask;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic walk;
        logic tick;
        logic fin;
        logic sched;
        logic announce;
    } cmd_t;

    typedef struct packed {
        logic lock_zero;
        logic lock_one;
    } status_t;

endpackage

### sv/bpts_ctrl.sv
// Controller state machine of the bitmap priority task scheduler.
// Sequences the table walk and the final scheduling step; uses bpts_pkg.
module bpts_ctrl #(
    parameter int NUM_PRIOS = bpts_pkg::NUM_PRIOS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [2:0]                   action,
    input  bpts_pkg::status_t            status,
    output logic                         busy,
    output bpts_pkg::cmd_t               cmd,
    output logic [$clog2(NUM_PRIOS)-1:0] idx
);

    localparam int PRW = $clog2(NUM_PRIOS);
    localparam logic [PRW-1:0] LAST_IDX = PRW'(NUM_PRIOS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]     state_reg, state_next;
    logic [PRW-1:0] idx_reg, idx_next;
    logic           tick_reg, tick_next;
    logic           sched_reg, sched_next;
    logic           ann_reg, ann_next;
    logic           accept;
    logic           walk_req;

    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        walk_req   = 1'b0;
        tick_next  = tick_reg;
        sched_next = sched_reg;
        ann_next   = ann_reg;
        if (accept)
        begin
            tick_next  = 1'b0;
            sched_next = 1'b0;
            ann_next   = 1'b0;
            case (action)
                bpts_pkg::ACT_START:
                begin
                    walk_req   = 1'b1;
                    sched_next = 1'b1;
                    ann_next   = 1'b1;
                end
                bpts_pkg::ACT_TICK:
                begin
                    walk_req   = 1'b1;
                    tick_next  = 1'b1;
                    sched_next = status.lock_zero;
                end
                bpts_pkg::ACT_DELAY:
                begin
                    walk_req   = status.lock_zero;
                    sched_next = status.lock_zero;
                end
                bpts_pkg::ACT_UNLOCK:
                begin
                    walk_req   = status.lock_one;
                    sched_next = status.lock_one;
                end
                default:
                begin
                    walk_req = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (accept)
                begin
                    state_next = walk_req ? ST_WALK : ST_FIN;
                end
            end
            ST_WALK:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + PRW'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            tick_reg  <= 1'b0;
            sched_reg <= 1'b0;
            ann_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            tick_reg  <= tick_next;
            sched_reg <= sched_next;
            ann_reg   <= ann_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign idx          = idx_reg;
    assign cmd.load     = accept;
    assign cmd.walk     = (state_reg == ST_WALK);
    assign cmd.tick     = tick_reg;
    assign cmd.fin      = (state_reg == ST_FIN);
    assign cmd.sched    = sched_reg;
    assign cmd.announce = ann_reg;

    a_fin_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |=> (state_reg == ST_IDLE))
        else $error("controller did not return to idle after finishing");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (idx_reg <= LAST_IDX))
        else $error("walk index out of range");

    a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && idx_reg == LAST_IDX) |=> (state_reg == ST_DRAIN))
        else $error("walk did not end at the last priority");

endmodule

### sv/bpts_datapath.sv
// Datapath of the bitmap priority task scheduler: ready bitmap, wait-count memory,
// lock count, running priority and the registered result. Uses bpts_pkg.
module bpts_datapath #(
    parameter int NUM_PRIOS   = bpts_pkg::NUM_PRIOS_DEF,
    parameter int DELAY_WIDTH = bpts_pkg::DELAY_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bpts_pkg::cmd_t               cmd,
    input  logic [$clog2(NUM_PRIOS)-1:0] idx,
    input  bpts_pkg::req_t               req,
    input  logic                         cfg_we,
    input  logic [31:0]                  cfg_wdata,
    output bpts_pkg::status_t            status,
    output logic                         result_valid,
    output bpts_pkg::rsp_t               result
);

    localparam int PRW = $clog2(NUM_PRIOS);
    localparam int PW  = (NUM_PRIOS > 32) ? NUM_PRIOS : 32;
    localparam int TW  = (DELAY_WIDTH > 16) ? DELAY_WIDTH : 16;
    localparam int PRO = (PRW > 5) ? PRW : 5;
    localparam logic [TW-1:0] DELAY_LIMIT = TW'({DELAY_WIDTH{1'b1}});

    logic [31:0]            present_reg;
    logic [NUM_PRIOS-1:0]   ready_reg, ready_next;
    logic [NUM_PRIOS-1:0]   valid_reg, valid_next;
    logic [7:0]             lock_reg, lock_next;
    logic [PRW-1:0]         cur_reg, cur_next;
    logic [DELAY_WIDTH-1:0] mem [NUM_PRIOS];
    logic [DELAY_WIDTH-1:0] rd_data_reg;
    logic                   rd_valid_reg;
    logic                   proc_reg;
    logic                   proc_tick_reg;
    logic [PRW-1:0]         proc_idx_reg;
    logic                   found_reg, found_next;
    logic [PRW-1:0]         found_idx_reg, found_idx_next;
    logic                   result_valid_reg;
    bpts_pkg::rsp_t         result_reg, result_next;

    logic [PW-1:0]          pres_wide;
    logic [NUM_PRIOS-1:0]   pres;
    logic [PW-1:0]          ready_wide;
    logic [PRO-1:0]         cur_wide;
    logic [TW-1:0]          ticks_wide;
    logic [TW-1:0]          ticks_sat;
    logic                   proc_pres;
    logic                   cnt_zero;
    logic                   tick_set;
    logic                   tick_dec;
    logic                   cand;
    logic                   sw;
    logic                   do_delay;

    assign pres_wide  = PW'(present_reg);
    assign pres       = pres_wide[NUM_PRIOS-1:0];
    assign ticks_wide = TW'(req.delay_ticks);
    assign ticks_sat  = (ticks_wide > DELAY_LIMIT) ? DELAY_LIMIT : ticks_wide;
    assign do_delay   = cmd.load && (req.action == bpts_pkg::ACT_DELAY);

    assign proc_pres = pres[proc_idx_reg];
    assign cnt_zero  = !rd_valid_reg || (rd_data_reg == '0);
    assign tick_set  = proc_reg && proc_tick_reg && proc_pres && cnt_zero;
    assign tick_dec  = proc_reg && proc_tick_reg && proc_pres && !cnt_zero;
    assign cand      = proc_reg && proc_pres && (ready_reg[proc_idx_reg] || tick_set);

    always_comb
    begin
        ready_next = ready_reg;
        valid_next = valid_reg;
        lock_next  = lock_reg;
        if (cmd.load)
        begin
            case (req.action)
                bpts_pkg::ACT_START:
                begin
                    ready_next = pres;
                    valid_next = valid_reg & ~pres;
                end
                bpts_pkg::ACT_DELAY:
                begin
                    ready_next[cur_reg] = 1'b0;
                    valid_next[cur_reg] = 1'b1;
                end
                bpts_pkg::ACT_LOCK:
                begin
                    if (lock_reg != bpts_pkg::LOCK_MAX)
                    begin
                        lock_next = lock_reg + 8'd1;
                    end
                end
                bpts_pkg::ACT_UNLOCK:
                begin
                    if (lock_reg != 8'd0)
                    begin
                        lock_next = lock_reg - 8'd1;
                    end
                end
                default:
                begin
                    lock_next = lock_reg;
                end
            endcase
        end
        if (tick_set)
        begin
            ready_next[proc_idx_reg] = 1'b1;
        end
    end

    always_comb
    begin
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        if (cmd.load)
        begin
            found_next = 1'b0;
        end
        else if (cand && !found_reg)
        begin
            found_next     = 1'b1;
            found_idx_next = proc_idx_reg;
        end
    end

    always_comb
    begin
        cur_next = cur_reg;
        sw       = 1'b0;
        if (cmd.fin && cmd.sched && found_reg)
        begin
            cur_next = found_idx_reg;
            sw       = cmd.announce || (found_idx_reg != cur_reg);
        end
    end

    assign ready_wide = PW'(ready_reg);
    assign cur_wide   = PRO'(cur_next);

    always_comb
    begin
        result_next              = result_reg;
        result_next.switch_now   = sw;
        result_next.running_prio = cur_wide[4:0];
        result_next.none_ready   = ((ready_reg & pres) == '0);
        result_next.lock_level   = lock_reg;
        result_next.ready_mask   = ready_wide[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg      <= '0;
            ready_reg        <= '0;
            valid_reg        <= '0;
            lock_reg         <= '0;
            cur_reg          <= '0;
            proc_reg         <= 1'b0;
            found_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                present_reg <= cfg_wdata;
            end
            ready_reg        <= ready_next;
            valid_reg        <= valid_next;
            lock_reg         <= lock_next;
            cur_reg          <= cur_next;
            proc_reg         <= cmd.walk;
            found_reg        <= found_next;
            result_valid_reg <= cmd.fin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk)
        begin
            rd_data_reg   <= mem[idx];
            rd_valid_reg  <= valid_reg[idx];
            proc_idx_reg  <= idx;
            proc_tick_reg <= cmd.tick;
        end
        if (do_delay)
        begin
            mem[cur_reg] <= ticks_sat[DELAY_WIDTH-1:0];
        end
        else if (tick_dec)
        begin
            mem[proc_idx_reg] <= rd_data_reg - DELAY_WIDTH'(1);
        end
        found_idx_reg <= found_idx_next;
        if (cmd.fin)
        begin
            result_reg <= result_next;
        end
    end

    assign status.lock_zero = (lock_reg == 8'd0);
    assign status.lock_one  = (lock_reg == 8'd1);
    assign result_valid     = result_valid_reg;
    assign result           = result_reg;

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |=> !result_valid_reg)
        else $error("result strobe held for more than one cycle");

    a_switch_needs_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.switch_now) |-> !result_reg.none_ready)
        else $error("switch reported with no ready task");

endmodule

### sv/bitmap_priority_task_scheduler.sv
// Bitmap priority task scheduler: ready bitmap, per-task wait counts and lock count.
// Instantiates bpts_ctrl and bpts_datapath; uses bpts_pkg.
//
// A request is taken at a rising edge where start is high and busy is low. It
// carries an action (start, tick, delay, lock, unlock) and a delay tick count.
// Exactly one result follows per request, shown for one cycle with result_valid
// high; the receiver cannot hold it off and must take it in that cycle.
// The task present mask is written through cfg_we and cfg_wdata; the user must
// write it only while idle, as the block itself does not enforce this. Lock, an
// unlock at zero, an unlock that leaves the scheduler locked, a delay while
// locked and an unknown action go from the accepting edge straight to the finish
// state. Start, tick and every action that reschedules walk the wait-count memory
// one priority per cycle and search for the lowest ready priority on the way,
// then pass through a drain state and the finish state. busy is low in the
// cycle that shows the result, so the next request may be accepted then.
// Reset clears the ready bitmap, the lock count, the running priority and the
// present mask, and marks every wait count as zero at once.
module bitmap_priority_task_scheduler #(
    parameter int NUM_PRIOS   = bpts_pkg::NUM_PRIOS_DEF,
    parameter int DELAY_WIDTH = bpts_pkg::DELAY_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  bpts_pkg::req_t item,
    input  logic           cfg_we,
    input  logic [31:0]    cfg_wdata,
    output logic           result_valid,
    output bpts_pkg::rsp_t result
);

    bpts_pkg::cmd_t               cmd;
    bpts_pkg::status_t            status;
    logic [$clog2(NUM_PRIOS)-1:0] idx;

    bpts_ctrl #(
        .NUM_PRIOS (NUM_PRIOS)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (item.action),
        .status (status),
        .busy   (busy),
        .cmd    (cmd),
        .idx    (idx)
    );

    bpts_datapath #(
        .NUM_PRIOS   (NUM_PRIOS),
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .idx          (idx),
        .req          (item),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
